@@ src/dpbp_pkg.sv @@
// ============================================================================
// dpbp_pkg: shared types and constants of the depth back-projection core
// Payload structs, controller/datapath command and status groups, register
// indexes, multiplier operand selects and fixed field widths.
// ============================================================================
package dpbp_pkg;

    // Raster limits.
    localparam int MAX_WIDTH = 4096;
    localparam int STRIDE    = 3;

    // Field and internal widths.
    localparam int COUNT_W = 12;
    localparam int PHASE_W = 3;
    localparam int WIDTH_W = 13;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 24;
    localparam int Z_W     = 20;
    localparam int COORD_W = 24;
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = 44;
    localparam int P1_W    = 36;
    localparam int HALF_W  = 18;
    localparam int ACC_W   = 61;
    localparam int MAG_W   = 33;

    // Configuration register indexes.
    localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd0;
    localparam logic [2:0] REG_CENTER_X         = 3'd1;
    localparam logic [2:0] REG_CENTER_Y         = 3'd2;
    localparam logic [2:0] REG_INV_FOCAL_X      = 3'd3;
    localparam logic [2:0] REG_INV_FOCAL_Y      = 3'd4;
    localparam logic [2:0] REG_INV_DEPTH_FACTOR = 3'd5;
    localparam logic [2:0] REG_MAX_DEPTH        = 3'd6;

    // Operand pairs of the shared multiplier.
    localparam logic [1:0] MUL_DEPTH  = 2'd0;  // raw depth times depth reciprocal
    localparam logic [1:0] MUL_OFFSET = 2'd1;  // depth times pixel offset
    localparam logic [1:0] MUL_LOW    = 2'd2;  // low half of that times focal reciprocal
    localparam logic [1:0] MUL_HIGH   = 2'd3;  // high half of that times focal reciprocal

    typedef struct packed {
        logic [15:0] depth_raw;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        start_of_frame;
    } pixel_t;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [19:0]        point_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
    } point_t;

    typedef struct packed {
        logic       accept;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       axis;
        logic       z_load;
        logic       p1_load;
        logic       acc_init;
        logic       acc_add;
        logic       res_load;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic keep;
        logic z_over;
        logic out_free;
    } dp_status_t;

endpackage

@@ src/dpbp_ctrl.sv @@
// ============================================================================
// dpbp_ctrl: sequencer of the depth back-projection core
// Steps one kept pixel through the shared multiplier: depth, then the x and
// y projections, then the output register; a depth over the limit ends it early.
// ============================================================================
module dpbp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dpbp_pkg::dp_status_t status,
    output dpbp_pkg::dp_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MZ   = 4'd1;
    localparam logic [3:0] ST_ZC   = 4'd2;
    localparam logic [3:0] ST_OFF  = 4'd3;
    localparam logic [3:0] ST_P1   = 4'd4;
    localparam logic [3:0] ST_LO   = 4'd5;
    localparam logic [3:0] ST_ACC0 = 4'd6;
    localparam logic [3:0] ST_ACC1 = 4'd7;
    localparam logic [3:0] ST_SAT  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       axis_reg;
    logic       axis_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        cmd          = '0;
        cmd.mul_sel  = dpbp_pkg::MUL_DEPTH;
        cmd.axis     = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.keep)
                begin
                    state_next = ST_MZ;
                    axis_next  = 1'b0;
                end
            end
            ST_MZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dpbp_pkg::MUL_DEPTH;
                state_next  = ST_ZC;
            end
            ST_ZC:
            begin
                cmd.z_load = 1'b1;
                state_next = status.z_over ? ST_IDLE : ST_OFF;
            end
            ST_OFF:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dpbp_pkg::MUL_OFFSET;
                state_next  = ST_P1;
            end
            ST_P1:
            begin
                cmd.p1_load = 1'b1;
                state_next  = ST_LO;
            end
            ST_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dpbp_pkg::MUL_LOW;
                state_next  = ST_ACC0;
            end
            ST_ACC0:
            begin
                // The low product is folded in while the high one is formed.
                cmd.acc_init = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = dpbp_pkg::MUL_HIGH;
                state_next   = ST_ACC1;
            end
            ST_ACC1:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.res_load = 1'b1;
                if (axis_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_OFF;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

@@ src/dpbp_datapath.sv @@
// ============================================================================
// dpbp_datapath: registers and arithmetic of the depth back-projection core
// Configuration registers, raster counters, one shared 20x24 multiplier,
// rounding accumulator, saturation and the output register.
// ============================================================================
module dpbp_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dpbp_pkg::pixel_t                      in_data,
    input  logic                                  cfg_we,
    input  logic [dpbp_pkg::IDX_W-1:0]            cfg_index,
    input  logic [dpbp_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output dpbp_pkg::point_t                      out_data,
    input  dpbp_pkg::dp_cmd_t                     cmd,
    output dpbp_pkg::dp_status_t                  status
);

    localparam logic [dpbp_pkg::MAG_W-1:0] SAT_POS = 33'd8388607;
    localparam logic [dpbp_pkg::MAG_W-1:0] SAT_NEG = 33'd8388608;

    // Configuration registers.
    logic [12:0] image_width_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [23:0] inv_focal_x_reg;
    logic [23:0] inv_focal_y_reg;
    logic [23:0] inv_depth_reg;
    logic [19:0] max_depth_reg;

    // Raster position.
    logic [dpbp_pkg::COUNT_W-1:0] col_cnt_reg;
    logic [dpbp_pkg::COUNT_W-1:0] row_cnt_reg;
    logic [dpbp_pkg::PHASE_W-1:0] col_ph_reg;
    logic [dpbp_pkg::PHASE_W-1:0] row_ph_reg;

    logic [dpbp_pkg::COUNT_W-1:0] col_cur;
    logic [dpbp_pkg::COUNT_W-1:0] row_cur;
    logic [dpbp_pkg::PHASE_W-1:0] col_ph_cur;
    logic [dpbp_pkg::PHASE_W-1:0] row_ph_cur;
    logic [dpbp_pkg::WIDTH_W-1:0] width_eff;
    logic [dpbp_pkg::WIDTH_W-1:0] col_inc;
    logic [dpbp_pkg::PHASE_W:0]   col_ph_inc;
    logic [dpbp_pkg::PHASE_W:0]   row_ph_inc;
    logic                         row_end;

    // Working registers of one pixel.
    dpbp_pkg::pixel_t             pix_reg;
    logic [dpbp_pkg::COUNT_W-1:0] col_reg;
    logic [dpbp_pkg::COUNT_W-1:0] row_reg;
    logic [dpbp_pkg::Z_W-1:0]     z_reg;
    logic [dpbp_pkg::MUL_P_W-1:0] mul_reg;
    logic [dpbp_pkg::P1_W-1:0]    p1_reg;
    logic [dpbp_pkg::ACC_W-1:0]   acc_reg;
    logic [dpbp_pkg::COORD_W-1:0] res_x_reg;
    logic [dpbp_pkg::COORD_W-1:0] res_y_reg;
    dpbp_pkg::point_t             out_reg;
    logic                         out_valid_reg;

    logic [dpbp_pkg::MUL_A_W-1:0] mul_a;
    logic [dpbp_pkg::MUL_B_W-1:0] mul_b;
    logic [dpbp_pkg::MUL_P_W-1:0] mul_p;
    logic [15:0]                  pos_q4;
    logic [15:0]                  center;
    logic [23:0]                  inv_sel;
    logic                         off_neg;
    logic [15:0]                  off_mag;
    logic [40:0]                  z_sum;
    logic [32:0]                  z_full;
    logic [dpbp_pkg::MAG_W-1:0]   mag;
    logic [dpbp_pkg::MAG_W-1:0]   mag_neg;
    logic [dpbp_pkg::COORD_W-1:0] sat_val;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= 13'd640;
            center_x_reg    <= 16'd5107;
            center_y_reg    <= 16'd3970;
            inv_focal_x_reg <= 24'd43386;
            inv_focal_y_reg <= 24'd43509;
            inv_depth_reg   <= 24'd16777;
            max_depth_reg   <= 20'd393216;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dpbp_pkg::REG_IMAGE_WIDTH:      image_width_reg <= cfg_data[12:0];
                dpbp_pkg::REG_CENTER_X:         center_x_reg    <= cfg_data[15:0];
                dpbp_pkg::REG_CENTER_Y:         center_y_reg    <= cfg_data[15:0];
                dpbp_pkg::REG_INV_FOCAL_X:      inv_focal_x_reg <= cfg_data;
                dpbp_pkg::REG_INV_FOCAL_Y:      inv_focal_y_reg <= cfg_data;
                dpbp_pkg::REG_INV_DEPTH_FACTOR: inv_depth_reg   <= cfg_data;
                dpbp_pkg::REG_MAX_DEPTH:        max_depth_reg   <= cfg_data[19:0];
                default:                        ;
            endcase
        end
    end

    // ---------------------------------------------------------------- raster
    // A start-of-frame pixel sees the counters as cleared.
    assign col_cur    = in_data.start_of_frame ? '0 : col_cnt_reg;
    assign row_cur    = in_data.start_of_frame ? '0 : row_cnt_reg;
    assign col_ph_cur = in_data.start_of_frame ? '0 : col_ph_reg;
    assign row_ph_cur = in_data.start_of_frame ? '0 : row_ph_reg;

    always_comb
    begin
        priority if (image_width_reg == '0)
            width_eff = 13'd1;
        else if (image_width_reg > dpbp_pkg::WIDTH_W'(dpbp_pkg::MAX_WIDTH))
            width_eff = dpbp_pkg::WIDTH_W'(dpbp_pkg::MAX_WIDTH);
        else
            width_eff = image_width_reg;
    end

    assign col_inc    = {1'b0, col_cur} + 13'd1;
    assign row_end    = (col_inc >= width_eff);
    assign col_ph_inc = {1'b0, col_ph_cur} + 4'd1;
    assign row_ph_inc = {1'b0, row_ph_cur} + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            col_ph_reg  <= '0;
            row_ph_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (row_end)
            begin
                col_cnt_reg <= '0;
                col_ph_reg  <= '0;
                row_cnt_reg <= row_cur + 12'd1;
                row_ph_reg  <= (row_ph_inc >= 4'(dpbp_pkg::STRIDE)) ? '0
                                                                     : row_ph_inc[2:0];
            end
            else
            begin
                col_cnt_reg <= col_inc[11:0];
                col_ph_reg  <= (col_ph_inc >= 4'(dpbp_pkg::STRIDE)) ? '0
                                                                     : col_ph_inc[2:0];
                row_cnt_reg <= row_cur;
                row_ph_reg  <= row_ph_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= in_data;
            col_reg <= col_cur;
            row_reg <= row_cur;
        end
    end

    // ---------------------------------------------------------------- arithmetic
    assign pos_q4  = cmd.axis ? {row_reg, 4'd0} : {col_reg, 4'd0};
    assign center  = cmd.axis ? center_y_reg : center_x_reg;
    assign inv_sel = cmd.axis ? inv_focal_y_reg : inv_focal_x_reg;
    assign off_neg = (pos_q4 < center);
    assign off_mag = off_neg ? (center - pos_q4) : (pos_q4 - center);

    always_comb
    begin
        unique case (cmd.mul_sel)
            dpbp_pkg::MUL_DEPTH:
            begin
                mul_a = {4'd0, pix_reg.depth_raw};
                mul_b = inv_depth_reg;
            end
            dpbp_pkg::MUL_OFFSET:
            begin
                mul_a = z_reg;
                mul_b = {8'd0, off_mag};
            end
            dpbp_pkg::MUL_LOW:
            begin
                mul_a = {2'd0, p1_reg[dpbp_pkg::HALF_W-1:0]};
                mul_b = inv_sel;
            end
            dpbp_pkg::MUL_HIGH:
            begin
                mul_a = {2'd0, p1_reg[dpbp_pkg::P1_W-1:dpbp_pkg::HALF_W]};
                mul_b = inv_sel;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Depth rounded from Q16.24 to Q4.16.
    assign z_sum  = {1'b0, mul_reg[39:0]} + 41'd128;
    assign z_full = z_sum[40:8];

    // Coordinate magnitude rounded to Q.16 and saturated for its sign.
    assign mag     = acc_reg[dpbp_pkg::ACC_W-1:28];
    assign mag_neg = (mag > SAT_NEG) ? SAT_NEG : mag;

    always_comb
    begin
        if (off_neg)
            sat_val = 24'(33'd0 - mag_neg);
        else
            sat_val = (mag > SAT_POS) ? SAT_POS[23:0] : mag[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            mul_reg <= mul_p;
        if (cmd.z_load)
            z_reg <= z_full[19:0];
        if (cmd.p1_load)
            p1_reg <= mul_reg[dpbp_pkg::P1_W-1:0];
        if (cmd.acc_init)
            acc_reg <= {17'd0, mul_reg} + (61'd1 << 27);
        else if (cmd.acc_add)
            acc_reg <= acc_reg + {mul_reg[42:0], 18'd0};
        if (cmd.res_load)
        begin
            if (cmd.axis)
                res_y_reg <= sat_val;
            else
                res_x_reg <= sat_val;
        end
        if (cmd.out_load)
        begin
            out_reg.point_x   <= res_x_reg;
            out_reg.point_y   <= res_y_reg;
            out_reg.point_z   <= z_reg;
            out_reg.out_red   <= pix_reg.red;
            out_reg.out_green <= pix_reg.green;
            out_reg.out_blue  <= pix_reg.blue;
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign status.keep     = (col_ph_cur == '0) && (row_ph_cur == '0);
    assign status.z_over   = (z_full > {13'd0, max_depth_reg});
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

@@ src/depth_pixel_back_projection_core.sv @@
// ============================================================================
// depth_pixel_back_projection_core: pinhole back-projection of depth pixels
// Turns a raster stream of depth plus color pixels into colored 3D points.
// ============================================================================
// Usage.
// Pixels enter in raster order on the in channel (valid/ready); a transfer
// with start_of_frame set marks row 0, column 0. Only pixels whose row and
// column are both multiples of the stride are projected. Each kept pixel
// with depth not above max_depth yields one point on the out channel: x and
// y in signed Q8.16 metres (saturated), z in Q4.16 metres, color unchanged.
// Timing. A pixel off the stride grid is only counted; in_ready stays high.
// A grid pixel runs the whole sequence, or stops after the depth check if
// its depth is rejected; no new pixel is taken until it is done. Every
// product goes through one shared 20x24 multiplier (depth, then offset, low
// and high partial products per axis), and that multiplier sets the rate.
// Stalls. The output register holds a finished point until out_ready takes
// it, while the next pixel is already accepted and worked on; the sequence
// only waits at its last step if the previous point is still unclaimed.
// Reset. rst_n clears the raster counters, the sequencer and out_valid, and
// loads the configuration registers with their default camera values.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, which the core itself does not enforce.
// ============================================================================
module depth_pixel_back_projection_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  dpbp_pkg::pixel_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output dpbp_pkg::point_t           out_data,
    input  logic                       cfg_we,
    input  logic [dpbp_pkg::IDX_W-1:0] cfg_index,
    input  logic [dpbp_pkg::CFG_W-1:0] cfg_data
);

    // Command and status groups between the sequencer and the datapath.
    dpbp_pkg::dp_cmd_t    cmd;
    dpbp_pkg::dp_status_t status;

    // The sequencer owns the input handshake and the step order.
    dpbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath owns configuration, raster counters, arithmetic and the
    // output register.
    dpbp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ src/dpbp_checker.sv @@
// ============================================================================
// dpbp_checker: port-level checks of the depth back-projection core
// Watches the top-level ports and is attached to the core by a bind.
// ============================================================================
module dpbp_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  dpbp_pkg::pixel_t in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  dpbp_pkg::point_t out_data
);

    // A stalled input transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input payload changed while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

    // A new result is only loaded at the end of a busy sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a busy sequence");

    // Zero depth projects onto the optical axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.point_z == '0)
            |-> (out_data.point_x == '0) && (out_data.point_y == '0))
    else $error("zero depth gave a point off the axis");

endmodule

bind depth_pixel_back_projection_core dpbp_checker u_checker (.*);

@@ tb/sv/depth_pixel_back_projection_core_tb.sv @@
// ============================================================================
// depth_pixel_back_projection_core_tb: self-checking bench of the projection core
// Streams raster pixels into the core and predicts every point it should emit.
// Each point taken from the output is checked against the oldest prediction.
// The run covers reset values, depth limits, saturation, frame markers, width
// limits, a long output stall and several mixes of idle cycles.
// ============================================================================
module depth_pixel_back_projection_core_tb;

    // After the last expected point a dropped pixel may still be in flight,
    // so quiet periods wait DRAIN_CYCLES more after that point.
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 600000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    dpbp_pkg::pixel_t in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    dpbp_pkg::point_t out_data;
    logic                         cfg_we    = 1'b0;
    logic [dpbp_pkg::IDX_W-1:0]   cfg_index = dpbp_pkg::REG_IMAGE_WIDTH;
    logic [dpbp_pkg::CFG_W-1:0]   cfg_data  = '0;

    // Camera settings as the core should hold them; they start at the reset values.
    logic [12:0] cam_width = 13'd640;
    logic [15:0] cam_cx    = 16'd5107;
    logic [15:0] cam_cy    = 16'd3970;
    logic [23:0] cam_ifx   = 24'd43386;
    logic [23:0] cam_ify   = 24'd43509;
    logic [23:0] cam_idf   = 24'd16777;
    logic [19:0] cam_zmax  = 20'd393216;

    // Raster position of the next pixel and its position modulo the stride.
    logic [11:0] next_col  = '0;
    logic [11:0] next_row  = '0;
    logic [2:0]  col_phase = '0;
    logic [2:0]  row_phase = '0;

    dpbp_pkg::point_t expected_points[$];

    int pixels_sent     = 0;
    int points_expected = 0;
    int points_checked  = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    // The output stall is requested by flipping this token; the receiver
    // process notices the change and counts the stall down on its own.
    logic hold_token = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;

    depth_pixel_back_projection_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Safety net: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d points outstanding",
                     cycle_count, expected_points.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // One axis of the projection: (pos*16 - center) * z * 1/f, where the
    // product is Q.44 and gets rounded half away from zero to Q.16, then
    // saturated to the signed 24-bit range.
    function automatic logic [23:0] axis_coord(input logic [11:0] pos,
                                               input logic [15:0] center,
                                               input logic [63:0] z,
                                               input logic [23:0] inv);
        logic [63:0] scaled;
        logic [63:0] offset;
        logic [63:0] mag;
        logic        neg;
        scaled = {48'd0, pos, 4'd0};
        neg    = scaled < {48'd0, center};
        offset = neg ? {48'd0, center} - scaled : scaled - {48'd0, center};
        mag    = offset * z * {40'd0, inv};
        mag    = (mag + (64'd1 << 27)) >> 28;
        if (neg)
        begin
            if (mag > 64'd8388608)
                mag = 64'd8388608;
            mag = 64'd0 - mag;
            return mag[23:0];
        end
        if (mag > 64'd8388607)
            mag = 64'd8388607;
        return mag[23:0];
    endfunction

    // Follows the raster for one transferred pixel and queues the point it
    // yields, if it lies on the stride grid and is not too deep.
    task automatic project_pixel(input dpbp_pkg::pixel_t px);
        logic [12:0]      w;
        logic [63:0]      z;
        dpbp_pkg::point_t pt;
        if (px.start_of_frame)
        begin
            next_col  = '0;
            next_row  = '0;
            col_phase = '0;
            row_phase = '0;
        end
        w = cam_width;
        if (w == 13'd0)
            w = 13'd1;
        else if (w > 13'(dpbp_pkg::MAX_WIDTH))
            w = 13'(dpbp_pkg::MAX_WIDTH);
        if (col_phase == 3'd0 && row_phase == 3'd0)
        begin
            z = ({48'd0, px.depth_raw} * {40'd0, cam_idf} + 64'd128) >> 8;
            if (z <= {44'd0, cam_zmax})
            begin
                pt.point_x   = axis_coord(next_col, cam_cx, z, cam_ifx);
                pt.point_y   = axis_coord(next_row, cam_cy, z, cam_ify);
                pt.point_z   = z[19:0];
                pt.out_red   = px.red;
                pt.out_green = px.green;
                pt.out_blue  = px.blue;
                expected_points.insert(expected_points.size(), pt);
                points_expected++;
            end
        end
        // The row counter wraps at 4096 while its phase keeps counting.
        if (32'(next_col) + 1 >= 32'(w))
        begin
            next_col  = '0;
            col_phase = '0;
            next_row  = next_row + 12'd1;
            row_phase = (row_phase + 1 >= dpbp_pkg::STRIDE) ? 3'd0 : row_phase + 3'd1;
        end
        else
        begin
            next_col  = next_col + 12'd1;
            col_phase = (col_phase + 1 >= dpbp_pkg::STRIDE) ? 3'd0 : col_phase + 3'd1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("MISMATCH: %s", msg);
    endtask

    // Output side. Ready is chosen at the rising edge; a transfer is recognized
    // at the falling edge before it, when valid, ready and data are all settled.
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(negedge clk)
    begin
        dpbp_pkg::point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
                report_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d",
                                          out_data.point_x, out_data.point_y,
                                          out_data.point_z));
            else
            begin
                want = expected_points.pop_front();
                points_checked++;
                if (out_data.point_x !== want.point_x)
                    report_mismatch($sformatf("point %0d: x got %0d want %0d",
                                    points_checked, out_data.point_x, want.point_x));
                if (out_data.point_y !== want.point_y)
                    report_mismatch($sformatf("point %0d: y got %0d want %0d",
                                    points_checked, out_data.point_y, want.point_y));
                if (out_data.point_z !== want.point_z)
                    report_mismatch($sformatf("point %0d: z got %0d want %0d",
                                    points_checked, out_data.point_z, want.point_z));
                if (out_data.out_red !== want.out_red)
                    report_mismatch($sformatf("point %0d: red got %0d want %0d",
                                    points_checked, out_data.out_red, want.out_red));
                if (out_data.out_green !== want.out_green)
                    report_mismatch($sformatf("point %0d: green got %0d want %0d",
                                    points_checked, out_data.out_green, want.out_green));
                if (out_data.out_blue !== want.out_blue)
                    report_mismatch($sformatf("point %0d: blue got %0d want %0d",
                                    points_checked, out_data.out_blue, want.out_blue));
            end
        end
    end

    // Offers one pixel, after a random number of idle cycles, and returns at
    // the rising edge where the transfer happens. Valid stays high into the
    // next call when no idle cycle follows.
    task automatic send_pixel(input dpbp_pkg::pixel_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        project_pixel(px);
        pixels_sent++;
        @(posedge clk);
    endtask

    // Lets every expected point come out, then gives a dropped pixel still in
    // the pipeline time to finish, so that the core is idle afterwards.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [dpbp_pkg::IDX_W-1:0] index,
                             input logic [dpbp_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            dpbp_pkg::REG_IMAGE_WIDTH:      cam_width = value[12:0];
            dpbp_pkg::REG_CENTER_X:         cam_cx    = value[15:0];
            dpbp_pkg::REG_CENTER_Y:         cam_cy    = value[15:0];
            dpbp_pkg::REG_INV_FOCAL_X:      cam_ifx   = value;
            dpbp_pkg::REG_INV_FOCAL_Y:      cam_ify   = value;
            dpbp_pkg::REG_INV_DEPTH_FACTOR: cam_idf   = value;
            dpbp_pkg::REG_MAX_DEPTH:        cam_zmax  = value[19:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic dpbp_pkg::pixel_t make_pixel(input logic [15:0] raw, input logic sof);
        dpbp_pkg::pixel_t px;
        px.depth_raw      = raw;
        px.red            = 8'($urandom);
        px.green          = 8'($urandom);
        px.blue           = 8'($urandom);
        px.start_of_frame = sof;
        return px;
    endfunction

    // Mostly depths that land inside a plausible range, sometimes any value.
    function automatic logic [15:0] random_depth();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 8191));
        endcase
    endfunction

    // Picks a fresh camera; the core must be idle when this is called.
    task automatic camera_random();
        logic [dpbp_pkg::CFG_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 24'($urandom_range(0, 2));
            1:       v = 24'($urandom_range(13, 40));
            default: v = 24'($urandom_range(3, 12));
        endcase
        cfg_write(dpbp_pkg::REG_IMAGE_WIDTH, v);
        v = $urandom_range(1) ? 24'($urandom_range(0, 65535)) : 24'($urandom_range(0, 400));
        cfg_write(dpbp_pkg::REG_CENTER_X, v);
        v = $urandom_range(1) ? 24'($urandom_range(0, 65535)) : 24'($urandom_range(0, 400));
        cfg_write(dpbp_pkg::REG_CENTER_Y, v);
        v = $urandom_range(1) ? 24'($urandom_range(1, 24'hFFFFFF))
                              : 24'($urandom_range(20000, 70000));
        cfg_write(dpbp_pkg::REG_INV_FOCAL_X, v);
        v = $urandom_range(1) ? 24'($urandom_range(1, 24'hFFFFFF))
                              : 24'($urandom_range(20000, 70000));
        cfg_write(dpbp_pkg::REG_INV_FOCAL_Y, v);
        case ($urandom_range(9))
            0, 1, 2:    v = 24'($urandom_range(1, 24'hFFFFFF));
            3, 4, 5:    v = 24'd16777;
            default:    v = 24'($urandom_range(1, 65535));
        endcase
        cfg_write(dpbp_pkg::REG_INV_DEPTH_FACTOR, v);
        v = $urandom_range(1) ? 24'hFFFFF : 24'($urandom_range(0, 20'hFFFFF));
        cfg_write(dpbp_pkg::REG_MAX_DEPTH, v);
    endtask

    // A short raster run that starts with a frame marker, with shallow depths.
    task automatic raster_walk(input int count);
        for (int k = 0; k < count; k++)
            send_pixel(make_pixel(16'($urandom_range(0, 1000)), k == 0));
    endtask

    // The first pixels run with the camera left at its reset values.
    // Zero depth is kept, and the cutoff sits between raw 6000 and 6001.
    task automatic test_reset_values();
        send_pixel(make_pixel(16'd0, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 1'b0));
        send_pixel(make_pixel(16'd1, 1'b0));
        send_pixel(make_pixel(16'd6000, 1'b0));
        send_pixel(make_pixel(16'd5, 1'b0));
        send_pixel(make_pixel(16'd5, 1'b0));
        send_pixel(make_pixel(16'd6001, 1'b0));
        wait_for_idle();
    endtask

    // Every pixel here carries a frame marker, so each one sits at the
    // origin of the grid and only the depth decides whether it is kept.
    task automatic test_depth_threshold();
        // A reciprocal of 256 makes z equal to the raw depth.
        cfg_write(dpbp_pkg::REG_INV_DEPTH_FACTOR, 24'd256);
        cfg_write(dpbp_pkg::REG_MAX_DEPTH, 24'd1000);
        send_pixel(make_pixel(16'd1000, 1'b1));
        send_pixel(make_pixel(16'd1001, 1'b1));
        send_pixel(make_pixel(16'd0, 1'b1));
        wait_for_idle();
        cfg_write(dpbp_pkg::REG_MAX_DEPTH, 24'd0);
        send_pixel(make_pixel(16'd0, 1'b1));
        send_pixel(make_pixel(16'd1, 1'b1));
        wait_for_idle();
        // With the largest reciprocal, raw 15 is the last depth in range.
        cfg_write(dpbp_pkg::REG_INV_DEPTH_FACTOR, 24'hFFFFFF);
        cfg_write(dpbp_pkg::REG_MAX_DEPTH, 24'hFFFFF);
        send_pixel(make_pixel(16'd15, 1'b1));
        send_pixel(make_pixel(16'd16, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 1'b1));
        wait_for_idle();
        cfg_write(dpbp_pkg::REG_INV_DEPTH_FACTOR, 24'd1);
        send_pixel(make_pixel(16'hFFFF, 1'b1));
        wait_for_idle();
    endtask

    // Largest focal reciprocals and near-maximum depth: x runs from zero into
    // positive saturation along the row, and y sits at negative saturation.
    task automatic test_saturation();
        cfg_write(dpbp_pkg::REG_IMAGE_WIDTH, 24'd16);
        cfg_write(dpbp_pkg::REG_CENTER_X, 24'd0);
        cfg_write(dpbp_pkg::REG_CENTER_Y, 24'd65535);
        cfg_write(dpbp_pkg::REG_INV_FOCAL_X, 24'hFFFFFF);
        cfg_write(dpbp_pkg::REG_INV_FOCAL_Y, 24'hFFFFFF);
        cfg_write(dpbp_pkg::REG_INV_DEPTH_FACTOR, 24'hFFFFFF);
        for (int k = 0; k < 10; k++)
            send_pixel(make_pixel(16'd15, k == 0));
        wait_for_idle();
    endtask

    // A marker at the end of the second row restarts the raster; afterwards the
    // stream runs on without any marker and the counters simply continue.
    task automatic test_frame_markers();
        cfg_write(dpbp_pkg::REG_IMAGE_WIDTH, 24'd3);
        cfg_write(dpbp_pkg::REG_CENTER_X, 24'd24);
        cfg_write(dpbp_pkg::REG_CENTER_Y, 24'd24);
        cfg_write(dpbp_pkg::REG_INV_FOCAL_X, 24'd43386);
        cfg_write(dpbp_pkg::REG_INV_FOCAL_Y, 24'd43509);
        cfg_write(dpbp_pkg::REG_INV_DEPTH_FACTOR, 24'd256);
        cfg_write(dpbp_pkg::REG_MAX_DEPTH, 24'd65535);
        for (int k = 0; k < 5; k++)
            send_pixel(make_pixel(16'($urandom), k == 0));
        for (int k = 0; k < 10; k++)
            send_pixel(make_pixel(16'($urandom), k == 0));
        wait_for_idle();
    endtask

    // The largest width, then one above the limit, which must act as the
    // limit: the walk stays on the first row in both cases.
    task automatic test_width_clamp();
        cfg_write(dpbp_pkg::REG_MAX_DEPTH, 24'd1000);
        cfg_write(dpbp_pkg::REG_IMAGE_WIDTH, 24'd4096);
        raster_walk(24);
        wait_for_idle();
        cfg_write(dpbp_pkg::REG_IMAGE_WIDTH, 24'd8191);
        raster_walk(24);
        wait_for_idle();
    endtask

    // A width of zero acts as one, so every pixel starts a new row and only
    // the row phase decides which pixels are kept.
    task automatic test_width_zero();
        cfg_write(dpbp_pkg::REG_IMAGE_WIDTH, 24'd0);
        cfg_write(dpbp_pkg::REG_CENTER_Y, 24'd3970);
        raster_walk(24);
        wait_for_idle();
    endtask

    // The receiver refuses points for a long stretch while pixels keep
    // coming, so the core fills up and must hold its input off.
    task automatic test_output_stall();
        cfg_write(dpbp_pkg::REG_IMAGE_WIDTH, 24'd640);
        hold_token <= !hold_token;
        for (int k = 0; k < 40; k++)
            send_pixel(make_pixel(16'($urandom_range(0, 1000)), 1'b1));
        wait_for_idle();
    endtask

    // Random frames under two random cameras. Most frames are proper raster
    // runs with a leading marker; a few lack it or get a stray marker.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int sent;
        int first_point;
        int rows;
        int len;
        int w;
        logic sof;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (2)
        begin
            camera_random();
            w = (cam_width == 13'd0) ? 1 : int'(cam_width);
            sent = 0;
            first_point = points_expected;
            while ((sent < 50 || points_expected - first_point < 6) && sent < 160)
            begin
                rows = int'($urandom_range(1, 6));
                len  = w * rows + int'($urandom_range(0, 2));
                for (int k = 0; k < len; k++)
                begin
                    if (k == 0)
                        sof = ($urandom_range(9) != 0);
                    else
                        sof = ($urandom_range(99) < 2);
                    send_pixel(make_pixel(random_depth(), sof));
                    sent++;
                end
            end
            wait_for_idle();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_depth_threshold();
        test_saturation();
        test_frame_markers();
        test_width_clamp();
        test_width_zero();
        test_output_stall();
        test_random_traffic(0, 0);
        test_random_traffic(72, 0);
        test_random_traffic(0, 72);
        test_random_traffic(29, 29);
        wait_for_idle();

        $display("Sent %0d pixels and checked %0d points, with %0d mismatches.",
                 pixels_sent, points_checked, error_count);
        $display("Covered depth limits, saturation, markers, width limits, stalls.");
        if (error_count == 0 && expected_points.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
